/* design/vfc_pkg.sv */
// Package for the view frustum point cull block.
// Holds widths, operation and reason codes, register indexes and the config struct.
`timescale 1ns / 1ps
package vfc_pkg;

  localparam int CoordWidthDefault = 32;
  localparam int WordWidth = 32;
  localparam int FracBits = 16;
  localparam int ProdWidth = 2 * WordWidth;
  // Homogeneous sum: three floored products (48 bits) plus one word, grown by two bits.
  localparam int HomWidth = ProdWidth - FracBits + 2;
  localparam int CoefWidth = 17;
  localparam int ClipWidth = 31;
  localparam int CfgIdxWidth = 3;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTest = 1'b1;

  localparam logic [2:0] ReasonVisible = 3'd0;
  localparam logic [2:0] ReasonNear    = 3'd1;
  localparam logic [2:0] ReasonFar     = 3'd2;
  localparam logic [2:0] ReasonLeft    = 3'd3;
  localparam logic [2:0] ReasonRight   = 3'd4;
  localparam logic [2:0] ReasonTop     = 3'd5;
  localparam logic [2:0] ReasonBottom  = 3'd6;
  localparam logic [2:0] ReasonZeroW   = 3'd7;

  localparam logic [CfgIdxWidth-1:0] CfgNearClip = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgFarClip  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgHorizCos = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgHorizSin = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgVertCos  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgVertSin  = 3'd5;

  localparam logic [ClipWidth-1:0] NearReset = 31'd6554;
  localparam logic [ClipWidth-1:0] FarReset  = 31'd65536000;
  localparam logic [CoefWidth-1:0] CoefReset = 17'd46341;

  typedef struct packed {
    logic [ClipWidth-1:0] near_clip;
    logic [ClipWidth-1:0] far_clip;
    logic [CoefWidth-1:0] horiz_cos;
    logic [CoefWidth-1:0] horiz_sin;
    logic [CoefWidth-1:0] vert_cos;
    logic [CoefWidth-1:0] vert_sin;
  } cfg_t;

endpackage

/* design/vfc_if.sv */
// Handshake channels of the view frustum point cull block.
// Depends on vfc_pkg for the word width.
`timescale 1ns / 1ps
interface vfc_in_if
  import vfc_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [1:0]                  matrix_row;
  logic signed [WordWidth-1:0] word_0;
  logic signed [WordWidth-1:0] word_1;
  logic signed [WordWidth-1:0] word_2;
  logic signed [WordWidth-1:0] word_3;

  modport source (output valid, operation, matrix_row, word_0, word_1, word_2, word_3,
                  input ready);
  modport sink (input valid, operation, matrix_row, word_0, word_1, word_2, word_3,
                output ready);
endinterface

interface vfc_out_if;
  logic       valid;
  logic       ready;
  logic       visible;
  logic [2:0] cull_reason;

  modport source (output valid, visible, cull_reason, input ready);
  modport sink (input valid, visible, cull_reason, output ready);
endinterface

/* design/view_frustum_point_cull.sv */
// Top level of the view frustum point cull block: config registers, stall control
// and the transform, divider and plane-test pipeline. Depends on vfc_pkg and vfc_if.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake         Payload
//  in_i      in   valid/ready       operation, matrix_row, word_0..word_3
//  out_o     out  valid/ready       visible, cull_reason
//  cfg       in   cfg_we_i only     cfg_idx_i, cfg_data_i
//
// One item enters per cycle unless the pipeline stalls. A test item passes
// CoordWidth + 6 register stages: two transform stages, a pre-stage, one stage per
// quotient bit and a final stage in the divider, then two plane-test stages ending in
// the output register. The first stage loads at the accepting edge.
// Load items update the matrix at acceptance and produce no result.
// Reset clears the matrix, the config registers to their defaults and all valid bits.
// The whole pipeline advances together whenever the output register is empty or being
// taken; while a result waits unaccepted, every stage holds and in_i.ready is low.
module view_frustum_point_cull
  import vfc_pkg::*;
#(
  parameter int CoordWidth = CoordWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  vfc_in_if.sink                 in_i,
  vfc_out_if.source              out_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [ClipWidth-1:0]   cfg_data_i
);

  cfg_t                         cfg_q;
  logic                         en;
  logic                         accept;
  logic signed [WordWidth-1:0]  words [4];
  logic                         hom_valid;
  logic signed [HomWidth-1:0]   hom [4];
  logic signed [HomWidth-1:0]   nums [3];
  logic                         div_valid;
  logic                         div_zero_w;
  logic signed [CoordWidth-1:0] quot [3];

  // Config writes must arrive only while the pipeline is empty; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_clip <= NearReset;
      cfg_q.far_clip  <= FarReset;
      cfg_q.horiz_cos <= CoefReset;
      cfg_q.horiz_sin <= CoefReset;
      cfg_q.vert_cos  <= CoefReset;
      cfg_q.vert_sin  <= CoefReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNearClip: cfg_q.near_clip <= cfg_data_i;
        CfgFarClip:  cfg_q.far_clip  <= cfg_data_i;
        CfgHorizCos: cfg_q.horiz_cos <= cfg_data_i[CoefWidth-1:0];
        CfgHorizSin: cfg_q.horiz_sin <= cfg_data_i[CoefWidth-1:0];
        CfgVertCos:  cfg_q.vert_cos  <= cfg_data_i[CoefWidth-1:0];
        CfgVertSin:  cfg_q.vert_sin  <= cfg_data_i[CoefWidth-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign accept     = in_i.valid && en;

  assign words[0] = in_i.word_0;
  assign words[1] = in_i.word_1;
  assign words[2] = in_i.word_2;
  assign words[3] = in_i.word_3;

  vfc_transform u_transform (
    .clk_i,
    .rst_ni,
    .en_i         (en),
    .accept_i     (accept),
    .operation_i  (in_i.operation),
    .matrix_row_i (in_i.matrix_row),
    .word_i       (words),
    .valid_o      (hom_valid),
    .hom_o        (hom)
  );

  assign nums[0] = hom[0];
  assign nums[1] = hom[1];
  assign nums[2] = hom[2];

  vfc_divider #(.CoordWidth(CoordWidth)) u_divider (
    .clk_i,
    .rst_ni,
    .en_i     (en),
    .valid_i  (hom_valid),
    .num_i    (nums),
    .den_i    (hom[3]),
    .valid_o  (div_valid),
    .zero_w_o (div_zero_w),
    .quot_o   (quot)
  );

  vfc_plane_test #(.CoordWidth(CoordWidth)) u_plane_test (
    .clk_i,
    .rst_ni,
    .en_i      (en),
    .valid_i   (div_valid),
    .zero_w_i  (div_zero_w),
    .x_i       (quot[0]),
    .y_i       (quot[1]),
    .z_i       (quot[2]),
    .cfg_i     (cfg_q),
    .valid_o   (out_o.valid),
    .visible_o (out_o.visible),
    .reason_o  (out_o.cull_reason)
  );

endmodule

/* design/vfc_transform.sv */
// Matrix store and two-stage point transform (multiply, then floor and sum).
// Depends on vfc_pkg.
`timescale 1ns / 1ps
module vfc_transform
  import vfc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        accept_i,
  input  logic                        operation_i,
  input  logic [1:0]                  matrix_row_i,
  input  logic signed [WordWidth-1:0] word_i [4],
  output logic                        valid_o,
  output logic signed [HomWidth-1:0]  hom_o [4]
);

  logic signed [WordWidth-1:0] mat_q [16];
  logic signed [ProdWidth-1:0] prod_q [3][4];
  logic signed [WordWidth-1:0] row3_q [4];
  logic                        v1_q;
  logic                        v2_q;
  logic signed [HomWidth-1:0]  hom_d [4];
  logic signed [HomWidth-1:0]  hom_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
    end else if (accept_i && operation_i == OpLoad) begin
      for (int c = 0; c < 4; c++) mat_q[{matrix_row_i, 2'(c)}] <= word_i[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= accept_i && operation_i == OpTest;
      v2_q <= v1_q;
    end
  end

  // The matrix is sampled when the item enters, so later loads cannot disturb it.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) prod_q[r][c] <= word_i[r] * mat_q[r*4+c];
      end
      for (int c = 0; c < 4; c++) row3_q[c] <= mat_q[12+c];
      hom_q <= hom_d;
    end
  end

  // Dropping the low 16 bits of a signed product floors it to Q16.16.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hom_d[c] = HomWidth'(row3_q[c]);
      for (int r = 0; r < 3; r++) begin
        hom_d[c] = hom_d[c] + HomWidth'($signed(prod_q[r][c][ProdWidth-1:FracBits]));
      end
    end
  end

  assign valid_o = v2_q;
  assign hom_o   = hom_q;

endmodule

/* design/vfc_divider.sv */
// Three-lane pipelined restoring divider giving saturated Q16.16 quotients.
// One quotient bit per stage; depends on vfc_pkg.
`timescale 1ns / 1ps
module vfc_divider
  import vfc_pkg::*;
#(
  parameter int CoordWidth = CoordWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [HomWidth-1:0]   num_i [3],
  input  logic signed [HomWidth-1:0]   den_i,
  output logic                         valid_o,
  output logic                         zero_w_o,
  output logic signed [CoordWidth-1:0] quot_o [3]
);

  localparam int NumWidth = HomWidth + FracBits;
  localparam logic [CoordWidth-1:0] PosSat = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic [CoordWidth-1:0] NegSat = {1'b1, {(CoordWidth-1){1'b0}}};

  logic                  v_q    [0:CoordWidth];
  logic                  zw_q   [0:CoordWidth];
  logic [HomWidth-1:0]   d_q    [0:CoordWidth];
  logic [HomWidth-1:0]   rem_q  [0:CoordWidth][3];
  logic [CoordWidth-1:0] nl_q   [0:CoordWidth][3];
  logic [CoordWidth-1:0] q_q    [0:CoordWidth][3];
  logic                  neg_q  [0:CoordWidth][3];
  logic                  ovf_q  [0:CoordWidth][3];

  logic [HomWidth-1:0]   dabs;
  logic [HomWidth-1:0]   nabs   [3];
  logic [NumWidth-1:0]   nfull  [3];
  logic [NumWidth-1:0]   nhigh  [3];
  logic [HomWidth:0]     trial  [1:CoordWidth][3];
  logic                  ge     [1:CoordWidth][3];

  logic                  vo_q;
  logic                  zwo_q;
  logic signed [CoordWidth-1:0] quot_q [3];

  assign dabs = den_i[HomWidth-1] ? HomWidth'(-den_i) : den_i;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nabs[l]  = num_i[l][HomWidth-1] ? HomWidth'(-num_i[l]) : num_i[l];
      nfull[l] = {nabs[l], {FracBits{1'b0}}};
      nhigh[l] = nfull[l] >> CoordWidth;
    end
    for (int s = 1; s <= CoordWidth; s++) begin
      for (int l = 0; l < 3; l++) begin
        trial[s][l] = {rem_q[s-1][l], nl_q[s-1][l][CoordWidth-1]};
        ge[s][l]    = trial[s][l] >= {1'b0, d_q[s-1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= CoordWidth; s++) v_q[s] <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s <= CoordWidth; s++) v_q[s] <= v_q[s-1];
      vo_q <= v_q[CoordWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zw_q[0] <= den_i == '0;
      d_q[0]  <= dabs;
      for (int l = 0; l < 3; l++) begin
        // The top quotient bits are known to be zero unless the high part reaches d.
        ovf_q[0][l] <= nhigh[l] >= NumWidth'(dabs);
        rem_q[0][l] <= HomWidth'(nhigh[l]);
        nl_q[0][l]  <= nfull[l][CoordWidth-1:0];
        q_q[0][l]   <= '0;
        neg_q[0][l] <= num_i[l][HomWidth-1] ^ den_i[HomWidth-1];
      end
      for (int s = 1; s <= CoordWidth; s++) begin
        zw_q[s] <= zw_q[s-1];
        d_q[s]  <= d_q[s-1];
        for (int l = 0; l < 3; l++) begin
          rem_q[s][l] <= ge[s][l] ? HomWidth'(trial[s][l] - {1'b0, d_q[s-1]})
                                  : HomWidth'(trial[s][l]);
          nl_q[s][l]  <= nl_q[s-1][l] << 1;
          q_q[s][l]   <= {q_q[s-1][l][CoordWidth-2:0], ge[s][l]};
          neg_q[s][l] <= neg_q[s-1][l];
          ovf_q[s][l] <= ovf_q[s-1][l];
        end
      end
      zwo_q <= zw_q[CoordWidth];
      for (int l = 0; l < 3; l++) begin
        if (ovf_q[CoordWidth][l] || q_q[CoordWidth][l][CoordWidth-1]) begin
          quot_q[l] <= neg_q[CoordWidth][l] ? NegSat : PosSat;
        end else begin
          quot_q[l] <= neg_q[CoordWidth][l] ? -q_q[CoordWidth][l] : q_q[CoordWidth][l];
        end
      end
    end
  end

  assign valid_o  = vo_q;
  assign zero_w_o = zwo_q;
  assign quot_o   = quot_q;

endmodule

/* design/vfc_plane_test.sv */
// Clip-distance and side-plane tests in two stages, ending in the result register.
// Depends on vfc_pkg.
`timescale 1ns / 1ps
module vfc_plane_test
  import vfc_pkg::*;
#(
  parameter int CoordWidth = CoordWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic                         zero_w_i,
  input  logic signed [CoordWidth-1:0] x_i,
  input  logic signed [CoordWidth-1:0] y_i,
  input  logic signed [CoordWidth-1:0] z_i,
  input  cfg_t                         cfg_i,
  output logic                         valid_o,
  output logic                         visible_o,
  output logic [2:0]                   reason_o
);

  localparam int ExtWidth  = ((CoordWidth > 32) ? CoordWidth : 32) + 2;
  localparam int PrWidth   = CoordWidth + CoefWidth + 1;
  localparam int DistWidth = PrWidth + 2;
  localparam logic signed [ExtWidth-1:0]  OneExt = ExtWidth'(65536);
  localparam logic signed [DistWidth-1:0] OneSq  = DistWidth'(64'sd4294967296);

  logic signed [ExtWidth-1:0]  z_ext;
  logic signed [ExtWidth-1:0]  near_ext;
  logic signed [ExtWidth-1:0]  far_ext;
  logic                        v1_q, zw1_q, near1_q, far1_q;
  logic signed [PrWidth-1:0]   xc_q, zs_q, yc_q, zv_q;
  logic signed [DistWidth-1:0] d_left, d_right, d_top, d_bottom;
  logic [2:0]                  reason_d;
  logic                        vo_q;
  logic [2:0]                  reason_q;

  assign z_ext    = ExtWidth'(z_i);
  assign near_ext = $signed(ExtWidth'(cfg_i.near_clip));
  assign far_ext  = $signed(ExtWidth'(cfg_i.far_clip));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      vo_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zw1_q    <= zero_w_i;
      near1_q  <= (z_ext + OneExt) < near_ext;
      far1_q   <= (z_ext - OneExt) > far_ext;
      xc_q     <= x_i * $signed({1'b0, cfg_i.horiz_cos});
      zs_q     <= z_i * $signed({1'b0, cfg_i.horiz_sin});
      yc_q     <= y_i * $signed({1'b0, cfg_i.vert_cos});
      zv_q     <= z_i * $signed({1'b0, cfg_i.vert_sin});
      reason_q <= reason_d;
    end
  end

  // Distances are exact Q32.32 values; a plane culls when one exceeds 1.0.
  always_comb begin
    d_left   = -DistWidth'(xc_q) - DistWidth'(zs_q);
    d_right  =  DistWidth'(xc_q) - DistWidth'(zs_q);
    d_top    =  DistWidth'(yc_q) - DistWidth'(zv_q);
    d_bottom = -DistWidth'(yc_q) - DistWidth'(zv_q);
    if (zw1_q)                 reason_d = ReasonZeroW;
    else if (near1_q)          reason_d = ReasonNear;
    else if (far1_q)           reason_d = ReasonFar;
    else if (d_left > OneSq)   reason_d = ReasonLeft;
    else if (d_right > OneSq)  reason_d = ReasonRight;
    else if (d_top > OneSq)    reason_d = ReasonTop;
    else if (d_bottom > OneSq) reason_d = ReasonBottom;
    else                       reason_d = ReasonVisible;
  end

  assign valid_o   = vo_q;
  assign reason_o  = reason_q;
  assign visible_o = reason_q == ReasonVisible;

endmodule

/* design/vfc_checker.sv */
// Port-level assertions for the view frustum point cull block, bound to the top level.
// Depends on vfc_pkg for the reason codes.
`timescale 1ns / 1ps
module vfc_checker
  import vfc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_visible,
  input logic [2:0] out_reason
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_reason))
    else $error("result item changed while stalled");

  a_visible_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_visible == (out_reason == ReasonVisible))
    else $error("visible flag disagrees with cull reason");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

endmodule

bind view_frustum_point_cull vfc_checker u_vfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_visible (out_o.visible),
  .out_reason  (out_o.cull_reason)
);

/* bench/vfc_checker.sv */
// Checker for the view frustum point cull block: tracks the view matrix and config,
// predicts the cull reason of every test item and compares it. Depends on vfc_pkg, vfc_if.
`timescale 1ns / 1ps
module vfc_scoreboard
  import vfc_pkg::*;
#(
  parameter int CoordWidth = CoordWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  vfc_in_if                      in_m,
  vfc_out_if                     out_m,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [ClipWidth-1:0]   cfg_data_i,
  output int                     errors_o,
  output int                     pending_o
);

  localparam longint One = 64'sd65536;
  localparam int FifoDepth = 64;

  logic signed [WordWidth-1:0] view_mat [16];
  cfg_t                        cfg_q;
  // Expected reasons in acceptance order, far deeper than the pipeline.
  logic [2:0]                  want_mem [FifoDepth];
  logic [5:0]                  wr_ptr;
  logic [5:0]                  rd_ptr;
  int                          count;

  // Q16.16 quotient truncated toward zero, saturated to CoordWidth bits.
  function automatic longint div_q16(longint num, longint den);
    logic   neg;
    longint n, d, lim, ip, rem, f, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    lim = 64'sd1 <<< (CoordWidth - 1);
    ip = n / d;
    rem = n % d;
    f = 0;
    if (ip > (lim >>> 16)) begin
      q = lim;
    end else begin
      for (int i = 0; i < 16; i++) begin
        rem = rem <<< 1;
        f = f <<< 1;
        if (rem >= d) begin
          rem = rem - d;
          f = f | 1;
        end
      end
      q = (ip <<< 16) | f;
    end
    if (neg) return (q >= lim) ? -lim : -q;
    return (q >= lim) ? lim - 1 : q;
  endfunction

  // Exact plane distance test: a*ca + b*cb is beyond 1.0 in Q32.32.
  function automatic logic past_plane(longint a, longint ca, longint b, longint cb);
    return (a * ca + b * cb) > (One * One);
  endfunction

  function automatic logic [2:0] cull_of(longint px, longint py, longint pz);
    longint hom [4];
    longint x, y, z;
    longint hc, hs, vc, vs;
    hc = longint'(cfg_q.horiz_cos);
    hs = longint'(cfg_q.horiz_sin);
    vc = longint'(cfg_q.vert_cos);
    vs = longint'(cfg_q.vert_sin);
    for (int c = 0; c < 4; c++) begin
      hom[c] = longint'(view_mat[12 + c]);
      hom[c] += (px * longint'(view_mat[c])) >>> 16;
      hom[c] += (py * longint'(view_mat[4 + c])) >>> 16;
      hom[c] += (pz * longint'(view_mat[8 + c])) >>> 16;
    end
    if (hom[3] == 0) return ReasonZeroW;
    x = div_q16(hom[0], hom[3]);
    y = div_q16(hom[1], hom[3]);
    z = div_q16(hom[2], hom[3]);
    if (z + One < longint'(cfg_q.near_clip)) return ReasonNear;
    if (z - One > longint'(cfg_q.far_clip)) return ReasonFar;
    if (past_plane(-x, hc, -z, hs)) return ReasonLeft;
    if (past_plane(x, hc, -z, hs)) return ReasonRight;
    if (past_plane(y, vc, -z, vs)) return ReasonTop;
    if (past_plane(-y, vc, -z, vs)) return ReasonBottom;
    return ReasonVisible;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [2:0] want;
    if (!rst_ni) begin
      foreach (view_mat[i]) view_mat[i] = '0;
      cfg_q.near_clip = NearReset;
      cfg_q.far_clip  = FarReset;
      cfg_q.horiz_cos = CoefReset;
      cfg_q.horiz_sin = CoefReset;
      cfg_q.vert_cos  = CoefReset;
      cfg_q.vert_sin  = CoefReset;
      wr_ptr    = '0;
      rd_ptr    = '0;
      count     = 0;
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgNearClip: cfg_q.near_clip = cfg_data_i;
          CfgFarClip:  cfg_q.far_clip  = cfg_data_i;
          CfgHorizCos: cfg_q.horiz_cos = cfg_data_i[CoefWidth-1:0];
          CfgHorizSin: cfg_q.horiz_sin = cfg_data_i[CoefWidth-1:0];
          CfgVertCos:  cfg_q.vert_cos  = cfg_data_i[CoefWidth-1:0];
          CfgVertSin:  cfg_q.vert_sin  = cfg_data_i[CoefWidth-1:0];
          default: ;
        endcase
      end
      if (out_m.valid && out_m.ready) begin
        if (count == 0) begin
          $display("%0t: result with nothing expected: visible %0d reason %0d",
                   $time, out_m.visible, out_m.cull_reason);
          errors_o++;
        end else begin
          want   = want_mem[rd_ptr];
          rd_ptr = rd_ptr + 6'd1;
          count--;
          if (out_m.visible !== (want == ReasonVisible)) begin
            $display("%0t: visible expected %0d actual %0d", $time,
                     want == ReasonVisible, out_m.visible);
            errors_o++;
          end
          if (out_m.cull_reason !== want) begin
            $display("%0t: cull_reason expected %0d actual %0d", $time,
                     want, out_m.cull_reason);
            errors_o++;
          end
        end
      end
      if (in_m.valid && in_m.ready) begin
        if (in_m.operation == OpLoad) begin
          view_mat[{in_m.matrix_row, 2'd0}] = in_m.word_0;
          view_mat[{in_m.matrix_row, 2'd1}] = in_m.word_1;
          view_mat[{in_m.matrix_row, 2'd2}] = in_m.word_2;
          view_mat[{in_m.matrix_row, 2'd3}] = in_m.word_3;
        end else begin
          want_mem[wr_ptr] = cull_of(longint'(in_m.word_0), longint'(in_m.word_1),
                                     longint'(in_m.word_2));
          wr_ptr = wr_ptr + 6'd1;
          count++;
        end
      end
      pending_o = count;
    end
  end

endmodule

/* bench/tb_view_frustum_point_cull.sv */
// Testbench top for the view frustum point cull block: clock, reset, stimulus and verdict.
// Depends on vfc_pkg, vfc_if, vfc_checker and the block itself.
`timescale 1ns / 1ps
module tb_view_frustum_point_cull;
  import vfc_pkg::*;

  localparam int Latency = CoordWidthDefault + 7;
  localparam int StallLimit = 5000;
  localparam int One = 65536;
  // A register index past the end of the list; writes to it are ignored.
  localparam logic [CfgIdxWidth-1:0] CfgBeyondList = 3'd7;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [CfgIdxWidth-1:0] cfg_idx;
  logic [ClipWidth-1:0]   cfg_data;
  logic                   no_idle;
  int                     errors;
  int                     pending;
  int                     quiet_cycles;

  vfc_in_if  item_ch ();
  vfc_out_if cull_ch ();

  view_frustum_point_cull uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (item_ch),
    .out_o      (cull_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  vfc_scoreboard u_scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_m       (item_ch),
    .out_m      (cull_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // The result side stalls at random with a probability of 7 percent, except during the
  // stretch in which the stimulus asks for full throughput.
  always @(posedge clk_i) begin
    cull_ch.ready <= no_idle || ($urandom_range(99) >= 7);
  end

  // Watchdog: any cycle with an accepted item on either side restarts the count.
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (cull_ch.valid && cull_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one item and holds it until the block takes it. Valid stays high
  // into the next item unless an idle cycle is drawn.
  task automatic send(logic op, logic [1:0] row, int w0, int w1, int w2, int w3);
    while (!no_idle && $urandom_range(99) < 7) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid      <= 1'b1;
    item_ch.operation  <= op;
    item_ch.matrix_row <= row;
    item_ch.word_0     <= w0;
    item_ch.word_1     <= w1;
    item_ch.word_2     <= w2;
    item_ch.word_3     <= w3;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
  endtask

  task automatic test_point(int x, int y, int z);
    send(OpTest, 2'($urandom_range(3)), x, y, z, $urandom());
  endtask

  // Loads the identity with an optional translation in row 3.
  task automatic load_identity(int tx, int ty, int tz);
    send(OpLoad, 2'd0, One, 0, 0, 0);
    send(OpLoad, 2'd1, 0, One, 0, 0);
    send(OpLoad, 2'd2, 0, 0, One, 0);
    send(OpLoad, 2'd3, tx, ty, tz, One);
  endtask

  // Drains the block and lets the pipeline empty before a register write.
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxWidth-1:0] idx, logic [ClipWidth-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic int spread(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // A random well-formed view transform: scaled axes with small shear and a
  // translation; now and then a row carries raw noise or a zero w column.
  task automatic load_random_view();
    int pick;
    for (int r = 0; r < 4; r++) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        send(OpLoad, r[1:0], $urandom(), $urandom(), $urandom(), $urandom());
      end else if (r < 3) begin
        send(OpLoad, r[1:0],
             (r == 0) ? One / 2 + $urandom_range(One * 3 / 2) : spread(One / 8),
             (r == 1) ? One / 2 + $urandom_range(One * 3 / 2) : spread(One / 8),
             (r == 2) ? One / 2 + $urandom_range(One * 3 / 2) : spread(One / 8),
             (pick == 1) ? spread(One) : 0);
      end else begin
        send(OpLoad, 2'd3, spread(20 * One), spread(20 * One), spread(40 * One),
             (pick == 1) ? 0 : One + spread(One / 4));
      end
    end
  endtask

  task automatic random_phase(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        load_random_view();
      end else if (pick < 12) begin
        send(OpLoad, 2'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
             $urandom());
      end else if (pick < 20) begin
        test_point($urandom(), $urandom(), $urandom());
      end else begin
        test_point(spread(60 * One), spread(60 * One), spread(120 * One));
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    no_idle            = 1'b0;
    item_ch.valid      = 1'b0;
    item_ch.operation  = OpLoad;
    item_ch.matrix_row = '0;
    item_ch.word_0     = '0;
    item_ch.word_1     = '0;
    item_ch.word_2     = '0;
    item_ch.word_3     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // An all-zero matrix after reset gives a zero w for any point.
    test_point(One, One, One);
    load_identity(0, 0, 0);
    test_point(0, 0, 5 * One);          // inside
    test_point(0, 0, -5 * One);         // behind the near plane
    test_point(0, 0, 1100 * One);       // past the far plane
    test_point(-50 * One, 0, 5 * One);  // left
    test_point(50 * One, 0, 5 * One);   // right
    test_point(0, 50 * One, 5 * One);   // top
    test_point(0, -50 * One, 5 * One);  // bottom
    test_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    test_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    test_point(-1, -1, -1);
    // A tiny w pushes the quotients into saturation.
    send(OpLoad, 2'd3, 0, 0, 0, 1);
    test_point(100 * One, -100 * One, 100 * One);
    test_point(1, 0, 0);
    // A zero w column on a loaded matrix.
    send(OpLoad, 2'd3, One, One, One, 0);
    test_point(3 * One, 4 * One, 5 * One);
    settle();

    // Defaults, with a full-throughput stretch.
    no_idle = 1'b1;
    random_phase(70);
    no_idle = 1'b0;
    random_phase(50);
    settle();

    // Extremes: zero everything, including coefficients.
    for (int r = 0; r <= int'(CfgVertSin); r++) write_cfg(r[CfgIdxWidth-1:0], '0);
    load_identity(0, 0, 0);
    random_phase(80);
    settle();

    // Extremes: largest clips, coefficients of 1.0 or more, plus an index past the list.
    write_cfg(CfgNearClip, '1);
    write_cfg(CfgFarClip, '1);
    write_cfg(CfgHorizCos, 31'h1ffff);
    write_cfg(CfgHorizSin, 31'h1ffff);
    write_cfg(CfgVertCos, 31'd65536);
    write_cfg(CfgVertSin, 31'd65536);
    write_cfg(CfgBeyondList, 31'h1234);
    random_phase(70);
    settle();

    // Several random but sensible camera settings.
    for (int k = 0; k < 3; k++) begin
      write_cfg(CfgNearClip, ClipWidth'($urandom_range(One)));
      write_cfg(CfgFarClip, ClipWidth'($urandom_range(2000 * One, 10 * One)));
      write_cfg(CfgHorizCos, ClipWidth'($urandom_range(One)));
      write_cfg(CfgHorizSin, ClipWidth'($urandom_range(One)));
      write_cfg(CfgVertCos, ClipWidth'($urandom_range(One)));
      write_cfg(CfgVertSin, ClipWidth'(($urandom_range(9) == 0) ? $urandom()
                                                                 : $urandom_range(One)));
      load_identity(spread(5 * One), spread(5 * One), spread(5 * One));
      random_phase(70);
      settle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
